// File: rtl/cltk_pkg.sv
package cltk_pkg;

	localparam int ARG_LIMIT_DEFAULT = 32;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_end;
	} item_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic [5:0] arg_index;
		logic       arg_end;
		logic       line_done;
		logic [5:0] arg_count;
		logic       limit_hit;
	} res_t;

endpackage

// File: rtl/cltk_in_stage.sv
module cltk_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cltk_pkg::item_t  in_item,
	output logic             item_valid,
	output cltk_pkg::item_t  item,
	input  logic             advance
);

	logic            valid_s1;
	cltk_pkg::item_t item_s1;

	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/cltk_parse.sv
module cltk_parse #(
	parameter int ARG_LIMIT = cltk_pkg::ARG_LIMIT_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  cltk_pkg::item_t  item,
	output cltk_pkg::res_t   res
);

	typedef enum logic [2:0] {
		MODE_SKIP,
		MODE_PLAIN,
		MODE_PLAIN_ESC,
		MODE_QUOTED,
		MODE_QUOTED_ESC
	} mode_t;

	mode_t      mode_q, mode_d;
	logic       quote_single_q, quote_single_d;
	logic [5:0] args_done_q, args_done_d;
	logic       limit_q, limit_d;

	logic [7:0] c;
	logic       blank;
	logic       finish;
	logic       emit;
	logic [5:0] args_inc;
	logic       limit_inc;
	logic [7:0] close_quote;

	assign c           = item.char_in;
	assign blank       = (c == cltk_pkg::CH_SPACE) ||
	                     (c >= cltk_pkg::CH_TAB && c <= cltk_pkg::CH_CR);
	assign args_inc    = args_done_q + 6'd1;
	assign limit_inc   = args_inc >= 6'(ARG_LIMIT);
	assign close_quote = quote_single_q ? cltk_pkg::CH_SQUOTE : cltk_pkg::CH_DQUOTE;

	always_comb begin
		mode_d         = mode_q;
		quote_single_d = quote_single_q;
		args_done_d    = args_done_q;
		limit_d        = limit_q;
		finish         = 1'b0;
		emit           = 1'b0;
		res            = '0;
		if (item.line_end || c == cltk_pkg::CH_NUL) begin
			case (mode_q)
				MODE_PLAIN, MODE_PLAIN_ESC, MODE_QUOTED, MODE_QUOTED_ESC: finish = 1'b1;
				default: finish = 1'b0;
			endcase
			res.line_done  = 1'b1;
			res.arg_end    = finish;
			res.arg_index  = finish ? args_done_q : 6'd0;
			res.arg_count  = finish ? args_inc : args_done_q;
			res.limit_hit  = limit_q || (finish && limit_inc);
			mode_d         = MODE_SKIP;
			quote_single_d = 1'b0;
			args_done_d    = '0;
			limit_d        = 1'b0;
		end else begin
			if (!limit_q) begin
				case (mode_q)
					MODE_PLAIN_ESC: begin
						emit   = 1'b1;
						mode_d = MODE_PLAIN;
					end
					MODE_QUOTED_ESC: begin
						emit   = 1'b1;
						mode_d = MODE_QUOTED;
					end
					MODE_PLAIN: begin
						if (c == cltk_pkg::CH_BSLASH) begin
							mode_d = MODE_PLAIN_ESC;
						end else if (blank) begin
							finish = 1'b1;
						end else begin
							emit = 1'b1;
						end
					end
					MODE_QUOTED: begin
						if (c == cltk_pkg::CH_BSLASH) begin
							mode_d = MODE_QUOTED_ESC;
						end else if (c == close_quote) begin
							finish = 1'b1;
						end else begin
							emit = 1'b1;
						end
					end
					default: begin
						if (blank) begin
							mode_d = MODE_SKIP;
						end else if (c == cltk_pkg::CH_DQUOTE || c == cltk_pkg::CH_SQUOTE) begin
							mode_d         = MODE_QUOTED;
							quote_single_d = (c == cltk_pkg::CH_SQUOTE);
						end else if (c == cltk_pkg::CH_BSLASH) begin
							mode_d = MODE_PLAIN_ESC;
						end else begin
							emit   = 1'b1;
							mode_d = MODE_PLAIN;
						end
					end
				endcase
			end
			if (finish) begin
				args_done_d = args_inc;
				limit_d     = limit_inc;
				mode_d      = MODE_SKIP;
			end
			res.char_valid = emit;
			res.char_out   = emit ? c : 8'd0;
			res.arg_end    = finish;
			res.arg_index  = (emit || finish) ? args_done_q : 6'd0;
			res.arg_count  = args_done_d;
			res.limit_hit  = limit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_SKIP;
			quote_single_q <= 1'b0;
			args_done_q    <= '0;
			limit_q        <= 1'b0;
		end else if (step) begin
			mode_q         <= mode_d;
			quote_single_q <= quote_single_d;
			args_done_q    <= args_done_d;
			limit_q        <= limit_d;
		end
	end

endmodule

// File: rtl/cltk_out_stage.sv
module cltk_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  cltk_pkg::res_t  res,
	output logic            load_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output cltk_pkg::res_t  out_res
);

	logic           valid_s2;
	cltk_pkg::res_t res_s2;

	assign load_ready = !valid_s2 || out_ready;
	assign out_valid  = valid_s2;
	assign out_res    = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

// File: rtl/command_line_tokenizer_top.sv
// Throughput: one request per cycle when the master side does not stall; the parser mode
// register updates once per request. A request passes the input register, the parser and
// the output register. Backpressure on the master side stalls the input register, which holds
// its request. Reset (arst_n low, asynchronous): both stages empty, parser back to whitespace
// skipping, argument count and limit flag cleared.
module command_line_tokenizer_top #(
	parameter int ARG_LIMIT = cltk_pkg::ARG_LIMIT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // char_in[7:0]
	input  logic        s_axis_tlast,  // line_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // char_out[7:0], arg_index[13:8], arg_count[19:14], zero
	output logic [2:0]  m_axis_tuser,  // char_valid[0], arg_end[1], limit_hit[2]
	output logic        m_axis_tlast   // line_done
);

	cltk_pkg::item_t in_item;
	cltk_pkg::item_t item;
	cltk_pkg::res_t  res;
	cltk_pkg::res_t  out_res;
	logic            item_valid;
	logic            load_ready;
	logic            advance;

	assign in_item.char_in  = s_axis_tdata;
	assign in_item.line_end = s_axis_tlast;
	assign advance          = item_valid && load_ready;

	cltk_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance)
	);

	cltk_parse #(
		.ARG_LIMIT (ARG_LIMIT)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item),
		.res    (res)
	);

	cltk_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.res        (res),
		.load_ready (load_ready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = {4'd0, out_res.arg_count, out_res.arg_index, out_res.char_out};
	assign m_axis_tuser = {out_res.limit_hit, out_res.arg_end, out_res.char_valid};
	assign m_axis_tlast = out_res.line_done;

endmodule
